### rtl/core/mspc_pkg.sv
// Shared types and constants for the motor speed PID controller.
// No dependencies.
package mspc_pkg;

  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;
  localparam int TermFrac = 8;

  localparam logic [1:0] CMD_PULSE  = 2'd0;
  localparam logic [1:0] CMD_WINDOW = 2'd1;
  localparam logic [1:0] CMD_UPDATE = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_PROP_GAIN   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_OUT_LIMIT   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPEED_PP    = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SP_SCALE    = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_SP_LIMIT    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_FILT_ORDER  = 3'd7;

  typedef struct packed {
    logic accept;
    logic filt;
    logic div;
    logic fv_load;
    logic err;
    logic mul;
    logic clamp;
    logic sum;
  } mspc_cmd_t;

  typedef struct packed {
    logic bypass;
    logic div_last;
    logic out_free;
  } mspc_stat_t;

endpackage

### rtl/core/motor_speed_pid_controller_unit.sv
// Top level of the motor speed PID controller: sequencer plus datapath.
// Depends on mspc_pkg, mspc_ctrl and mspc_dp.
//
//   channel  | handshake                | beat
//   ---------+--------------------------+------------------------------------
//   in       | in_valid_i / in_stall_o  | cmd_i, adc_value_i
//   out      | out_valid_o / out_stall_i| duty, drive_sum, speed, error
//   cfg      | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
// Pulse and window beats pass without stalling the input. An update steps
// through filter, divide, filter-load, error, multiply, clamp and sum; with
// filter order 0 or 1 it skips the one-bit-per-cycle restoring divider of the
// speed filter and the load. The next beat is taken in the cycle after sum.
// Reset restores register defaults and clears counters, filter and PID state.
// A finished result waits in the output register; while it stays stalled,
// pulse and window beats still pass, but the next update stops at its last
// step with the input stalled.
module motor_speed_pid_controller_unit import mspc_pkg::*; #(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          cmd_i,
  input  logic [11:0]         adc_value_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [9:0]          duty_permille_o,
  output logic [9:0]          drive_sum_o,
  output logic [15:0]         filtered_speed_o,
  output logic signed [15:0]  speed_error_o
);

  mspc_cmd_t  ctl;
  mspc_stat_t stat;

  mspc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .cmd_i     (cmd_i),
    .stat_i    (stat),
    .cmd_o     (ctl),
    .busy_o    (in_stall_o)
  );

  mspc_dp #(
    .FRAC_BITS  (FRAC_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .cmd_i           (cmd_i),
    .adc_value_i     (adc_value_i),
    .ctl_i           (ctl),
    .stat_o          (stat),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .duty_permille_o (duty_permille_o),
    .drive_sum_o     (drive_sum_o),
    .filtered_speed_o(filtered_speed_o),
    .speed_error_o   (speed_error_o)
  );

endmodule

### rtl/core/mspc_ctrl.sv
// Sequencer for the controller: steps the datapath through one update.
// Depends on mspc_pkg.
module mspc_ctrl import mspc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] cmd_i,
  input  mspc_stat_t stat_i,
  output mspc_cmd_t  cmd_o,
  output logic       busy_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_FILT, S_DIV, S_FVLD, S_ERR, S_MUL, S_CLAMP, S_SUM
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   accept;

  assign accept = in_valid_i && !busy_q;
  assign busy_o = busy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && cmd_i == CMD_UPDATE) begin
            state_q <= S_FILT;
            busy_q  <= 1'b1;
          end
        end
        S_FILT:  state_q <= stat_i.bypass ? S_ERR : S_DIV;
        S_DIV: begin
          if (stat_i.div_last) state_q <= S_FVLD;
        end
        S_FVLD:  state_q <= S_ERR;
        S_ERR:   state_q <= S_MUL;
        S_MUL:   state_q <= S_CLAMP;
        S_CLAMP: state_q <= S_SUM;
        S_SUM: begin
          if (stat_i.out_free) begin
            state_q <= S_IDLE;
            busy_q  <= 1'b0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    unique case (state_q)
      S_FILT:  cmd_o.filt    = 1'b1;
      S_DIV:   cmd_o.div     = 1'b1;
      S_FVLD:  cmd_o.fv_load = 1'b1;
      S_ERR:   cmd_o.err     = 1'b1;
      S_MUL:   cmd_o.mul     = 1'b1;
      S_CLAMP: cmd_o.clamp   = 1'b1;
      S_SUM:   cmd_o.sum     = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/core/mspc_dp.sv
// Datapath: config registers, pulse counter, filter divider, PID terms
// and the output register. Depends on mspc_pkg.
module mspc_dp import mspc_pkg::*; #(
  parameter int FRAC_BITS   = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [1:0]          cmd_i,
  input  logic [11:0]         adc_value_i,
  input  mspc_cmd_t           ctl_i,
  output mspc_stat_t          stat_o,
  input  logic                out_stall_i,
  output logic                out_valid_o,
  output logic [9:0]          duty_permille_o,
  output logic [9:0]          drive_sum_o,
  output logic [15:0]         filtered_speed_o,
  output logic signed [15:0]  speed_error_o
);

  localparam int FW   = 16 + FRAC_BITS;
  localparam int NUMW = FW + 7;
  localparam int SPW  = COUNT_WIDTH + 8;
  localparam int DCW  = $clog2(NUMW);

  function automatic logic signed [18:0] clamp_term(input logic signed [41:0] v,
                                                    input logic [9:0] lim);
    logic signed [41:0] l;
    l = $signed({24'd0, lim, 8'd0});
    if (v > l) return l[18:0];
    if (v < -l) return 19'(-l);
    return v[18:0];
  endfunction

  logic [15:0] prop_q, integ_q, deriv_q, splim_q;
  logic [9:0]  olim_q;
  logic [7:0]  spp_q, sps_q;
  logic [6:0]  ford_q;

  logic [COUNT_WIDTH-1:0] pulse_q, latch_q;
  logic [FW-1:0]          fv_q;
  logic signed [19:0]     integ_term_q;
  logic signed [15:0]     prev_err_q;

  logic [15:0]        setp_q, speed_q;
  logic [NUMW-1:0]    num_q;
  logic [7:0]         rem_q;
  logic [DCW-1:0]     cnt_q;
  logic signed [15:0] err_q;
  logic signed [16:0] derr_q;
  logic signed [24:0] ierr_q;
  logic signed [33:0] prod_p_q, prod_d_q;
  logic signed [41:0] prod_i_q;
  logic signed [18:0] p_q, i_q, d_q;

  logic               out_valid_q;
  logic [9:0]         duty_q, drive_q;
  logic [15:0]        fspeed_q;
  logic signed [15:0] err_out_q;

  logic [19:0]        sp_full;
  logic [SPW-1:0]     speed_full;
  logic [NUMW-1:0]    fmul;
  logic [7:0]         r2;
  logic               ge;
  logic [15:0]        fspeed;
  logic signed [16:0] e17;
  logic signed [15:0] e16;
  logic signed [41:0] i_adj;
  logic signed [20:0] s;
  logic [9:0]         drive;

  assign sp_full    = adc_value_i * sps_q;
  assign speed_full = latch_q * spp_q;
  assign fmul       = NUMW'(ford_q - 7'd1) * NUMW'(fv_q);
  assign r2         = {rem_q[6:0], num_q[NUMW-1]};
  assign ge         = r2 >= {1'b0, ford_q};
  assign fspeed     = fv_q[FW-1:FRAC_BITS];
  assign e17        = $signed({1'b0, setp_q}) - $signed({1'b0, fspeed});

  always_comb begin
    if (e17 > 17'sd32767) e16 = 16'sh7FFF;
    else if (e17 < -17'sd32768) e16 = 16'sh8000;
    else e16 = e17[15:0];
  end

  assign i_adj = prod_i_q + (prod_i_q[41] ? 42'sd255 : 42'sd0);
  assign s     = 21'(p_q) + 21'(i_q) + 21'(d_q);

  always_comb begin
    if (s[20]) drive = '0;
    else if (s[20:8] > {3'd0, olim_q}) drive = olim_q;
    else drive = s[17:8];
  end

  assign stat_o.bypass   = ford_q <= 7'd1;
  assign stat_o.div_last = cnt_q == DCW'(NUMW - 1);
  assign stat_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prop_q       <= 16'd1024;
      integ_q      <= 16'd256;
      deriv_q      <= 16'd512;
      olim_q       <= 10'd1000;
      spp_q        <= 8'd75;
      sps_q        <= 8'd12;
      splim_q      <= 16'd3000;
      ford_q       <= 7'd4;
      pulse_q      <= '0;
      latch_q      <= '0;
      fv_q         <= '0;
      integ_term_q <= '0;
      prev_err_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_PROP_GAIN:  prop_q  <= cfg_data_i;
          REG_INTEG_GAIN: integ_q <= cfg_data_i;
          REG_DERIV_GAIN: deriv_q <= cfg_data_i;
          REG_OUT_LIMIT:  olim_q  <= cfg_data_i[9:0];
          REG_SPEED_PP:   spp_q   <= cfg_data_i[7:0];
          REG_SP_SCALE:   sps_q   <= cfg_data_i[7:0];
          REG_SP_LIMIT:   splim_q <= cfg_data_i;
          REG_FILT_ORDER: ford_q  <= cfg_data_i[6:0];
          default: ;
        endcase
      end
      if (ctl_i.accept) begin
        case (cmd_i)
          CMD_PULSE: pulse_q <= pulse_q + 1'b1;
          CMD_WINDOW: begin
            latch_q <= pulse_q;
            pulse_q <= '0;
          end
          default: ;
        endcase
      end
      if (ctl_i.filt && stat_o.bypass) fv_q <= {speed_q, {FRAC_BITS{1'b0}}};
      if (ctl_i.fv_load) fv_q <= num_q[FW-1:0];
      if (ctl_i.sum) begin
        integ_term_q <= 20'(i_q);
        prev_err_q   <= err_q;
      end
      if (ctl_i.sum) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      setp_q  <= (sp_full > {4'd0, splim_q}) ? splim_q : sp_full[15:0];
      speed_q <= (speed_full > SPW'(65535)) ? 16'hFFFF : speed_full[15:0];
    end
    if (ctl_i.filt) begin
      num_q <= NUMW'({speed_q, {FRAC_BITS{1'b0}}}) + fmul;
      rem_q <= '0;
      cnt_q <= '0;
    end
    if (ctl_i.div) begin
      rem_q <= ge ? r2 - {1'b0, ford_q} : r2;
      num_q <= {num_q[NUMW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
    if (ctl_i.err) begin
      err_q  <= e16;
      derr_q <= 17'(e16) - 17'(prev_err_q);
      ierr_q <= $signed({{1{e16[15]}}, e16, 8'd0}) + 25'(integ_term_q);
    end
    if (ctl_i.mul) begin
      prod_p_q <= $signed({1'b0, prop_q}) * 34'(err_q);
      prod_d_q <= $signed({1'b0, deriv_q}) * 34'(derr_q);
      prod_i_q <= $signed({1'b0, integ_q}) * 42'(ierr_q);
    end
    if (ctl_i.clamp) begin
      p_q <= clamp_term(42'(prod_p_q), olim_q);
      d_q <= clamp_term(42'(prod_d_q), olim_q);
      i_q <= clamp_term(i_adj >>> TermFrac, olim_q);
    end
    if (ctl_i.sum) begin
      drive_q   <= drive;
      duty_q    <= olim_q - drive;
      fspeed_q  <= fspeed;
      err_out_q <= err_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign duty_permille_o  = duty_q;
  assign drive_sum_o      = drive_q;
  assign filtered_speed_o = fspeed_q;
  assign speed_error_o    = err_out_q;

endmodule

### rtl/core/mspc_chk.sv
// Port-level checks for the motor speed PID controller, bound to the top.
// Depends on mspc_pkg.
module mspc_chk import mspc_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [1:0]  cmd_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [9:0]  duty_permille_o,
  input logic [9:0]  drive_sum_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(duty_permille_o))
    else $error("output beat dropped or changed while stalled");

  a_sum_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, duty_permille_o} + {1'b0, drive_sum_o}) <= 11'd1023)
    else $error("duty plus drive sum exceeds the limit range");

  a_update_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i == CMD_UPDATE |=> in_stall_o)
    else $error("update beat did not start the sequence");

  a_count_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && cmd_i != CMD_UPDATE |=> !in_stall_o)
    else $error("counter beat stalled the input");

endmodule

bind motor_speed_pid_controller_unit mspc_chk u_mspc_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .cmd_i          (cmd_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .duty_permille_o(duty_permille_o),
  .drive_sum_o    (drive_sum_o)
);
